// ===== hw/rtl/efg_pkg.sv =====
// shared types, constants and helpers for the event flag group
`timescale 1ns / 1ps

package efg_pkg;

    // waiter table size and derived widths
    localparam int WAITERS = 8;
    localparam int SLOT_W  = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int CNT_W   = $clog2(WAITERS + 1);
    localparam int FLAG_W  = 32;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_WAIT   = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    // result kinds
    typedef enum logic [2:0] {
        K_FLAGS  = 3'd0,
        K_WAKE   = 3'd1,
        K_MET    = 3'd2,
        K_QUEUED = 3'd3,
        K_POLL   = 3'd4,
        K_NOSLOT = 3'd5,
        K_FINISH = 3'd6,
        K_EMPTY  = 3'd7
    } t_kind;

    // one result transaction
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [FLAG_W-1:0] value;
        logic [2:0]        slot;
        logic              last;
    } t_res;

    // per-slot wait condition as kept in the slot table
    typedef struct packed {
        logic [FLAG_W-1:0] mask;
        logic              need_all;
        logic              clear_after;
    } t_slot_cfg;

    // any / all wait condition
    function automatic logic cond_holds(
        input logic [FLAG_W-1:0] cur,
        input logic [FLAG_W-1:0] want,
        input logic              all
    );
        logic [FLAG_W-1:0] hit;
        hit = cur & want;
        return all ? (hit == want) : (hit != '0);
    endfunction

endpackage

// ===== hw/rtl/efg_slot_ram.sv =====
// waiter slot table: condition and snapshot memories, registered read
`timescale 1ns / 1ps

module efg_slot_ram (
    input  logic                          i_clk,
    input  logic [efg_pkg::SLOT_W-1:0]    i_rd_addr,
    output efg_pkg::t_slot_cfg            o_rd_cfg,
    output logic [efg_pkg::FLAG_W-1:0]    o_rd_snap,
    input  logic [efg_pkg::SLOT_W-1:0]    i_wr_addr,
    input  logic                          i_cfg_we,
    input  efg_pkg::t_slot_cfg            i_wr_cfg,
    input  logic                          i_snap_we,
    input  logic [efg_pkg::FLAG_W-1:0]    i_wr_snap
);

    efg_pkg::t_slot_cfg             r_cfg_mem  [efg_pkg::WAITERS];
    logic [efg_pkg::FLAG_W-1:0]     r_snap_mem [efg_pkg::WAITERS];
    efg_pkg::t_slot_cfg             r_rd_cfg;
    logic [efg_pkg::FLAG_W-1:0]     r_rd_snap;

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_cfg_mem[i_wr_addr] <= i_wr_cfg;
        end
        if (i_snap_we) begin
            r_snap_mem[i_wr_addr] <= i_wr_snap;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_cfg  <= r_cfg_mem[i_rd_addr];
        r_rd_snap <= r_snap_mem[i_rd_addr];
    end

    assign o_rd_cfg  = r_rd_cfg;
    assign o_rd_snap = r_rd_snap;

endmodule

// ===== hw/rtl/efg_seq.sv =====
// operation sequencer: flag word, slot status bits and slot table walk
`timescale 1ns / 1ps

module efg_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_op,
    input  logic [31:0]            i_mask,
    input  logic                   i_need_all,
    input  logic                   i_clear_after,
    input  logic                   i_poll_only,
    input  logic [2:0]             i_slot_id,
    input  logic                   i_was_woken,
    output logic                   o_busy,
    output efg_pkg::t_res          o_res
);

    localparam int SW = efg_pkg::SLOT_W;
    localparam int CW = efg_pkg::CNT_W;
    localparam int W  = efg_pkg::WAITERS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SET  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [31:0]          r_flags, n_flags;
    logic [W-1:0]         r_busy, n_busy;
    logic [W-1:0]         r_done, n_done;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic                 r_chk_vld, n_chk_vld;
    logic [SW-1:0]        r_chk_idx, n_chk_idx;
    logic [SW-1:0]        r_fin_slot, n_fin_slot;
    logic                 r_fin_woken, n_fin_woken;

    // slot table interface
    logic [SW-1:0]        rd_addr;
    efg_pkg::t_slot_cfg   rd_cfg;
    logic [31:0]          rd_snap;
    logic [SW-1:0]        wr_addr;
    logic                 cfg_we;
    efg_pkg::t_slot_cfg   wr_cfg;
    logic                 snap_we;
    logic [31:0]          wr_snap;

    // helpers
    logic [SW-1:0]        sid;
    logic                 sid_ok;
    logic                 free_found;
    logic [SW-1:0]        free_idx;
    efg_pkg::t_res        res;
    logic [31:0]          fin_ret;
    logic                 fin_ok;

    efg_slot_ram u_ram (
        .i_clk      (i_clk),
        .i_rd_addr  (rd_addr),
        .o_rd_cfg   (rd_cfg),
        .o_rd_snap  (rd_snap),
        .i_wr_addr  (wr_addr),
        .i_cfg_we   (cfg_we),
        .i_wr_cfg   (wr_cfg),
        .i_snap_we  (snap_we),
        .i_wr_snap  (wr_snap)
    );

    // finish slot index and range check
    assign sid    = SW'(i_slot_id);
    assign sid_ok = (32'(i_slot_id) < 32'(W));

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = 0; k < W; k++) begin
            if (!r_busy[k] && !free_found) begin
                free_found = 1'b1;
                free_idx   = SW'(k);
            end
        end
    end

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_flags     = r_flags;
        n_busy      = r_busy;
        n_done      = r_done;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_fin_slot  = r_fin_slot;
        n_fin_woken = r_fin_woken;
        rd_addr     = sid;
        wr_addr     = r_chk_idx;
        cfg_we      = 1'b0;
        snap_we     = 1'b0;
        wr_cfg      = '{mask: i_mask, need_all: i_need_all, clear_after: i_clear_after};
        wr_snap     = r_flags;
        res         = '0;
        fin_ret     = '0;
        fin_ok      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (efg_pkg::t_op'(i_op))
                        efg_pkg::OP_SET: begin
                            n_flags   = r_flags | i_mask;
                            n_rd_idx  = '0;
                            n_chk_vld = 1'b0;
                            n_state   = S_SET;
                        end
                        efg_pkg::OP_CLEAR: begin
                            n_flags   = r_flags & ~i_mask;
                            res.valid = 1'b1;
                            res.kind  = efg_pkg::K_FLAGS;
                            res.value = r_flags & ~i_mask;
                            res.last  = 1'b1;
                        end
                        efg_pkg::OP_WAIT: begin
                            res.valid = 1'b1;
                            res.last  = 1'b1;
                            if (i_mask == '0) begin
                                res.kind = efg_pkg::K_EMPTY;
                            end else if (efg_pkg::cond_holds(r_flags, i_mask, i_need_all)) begin
                                res.kind  = efg_pkg::K_MET;
                                res.value = r_flags;
                                if (i_clear_after) begin
                                    n_flags = r_flags & ~i_mask;
                                end
                            end else if (i_poll_only) begin
                                res.kind = efg_pkg::K_POLL;
                            end else if (free_found) begin
                                res.kind         = efg_pkg::K_QUEUED;
                                res.slot         = 3'(free_idx);
                                wr_addr          = free_idx;
                                cfg_we           = 1'b1;
                                snap_we          = 1'b1;
                                wr_snap          = '0;
                                n_busy[free_idx] = 1'b1;
                                n_done[free_idx] = 1'b0;
                            end else begin
                                res.kind = efg_pkg::K_NOSLOT;
                            end
                        end
                        efg_pkg::OP_FINISH: begin
                            if (sid_ok && r_busy[sid]) begin
                                n_fin_slot  = sid;
                                n_fin_woken = i_was_woken;
                                n_state     = S_FIN;
                            end else begin
                                res.valid = 1'b1;
                                res.kind  = efg_pkg::K_FINISH;
                                res.slot  = i_slot_id;
                                res.last  = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SET: begin
                // issue the next slot read while checking the previous one
                rd_addr = r_rd_idx[SW-1:0];
                if (r_rd_idx != CW'(W)) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[SW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    if (r_busy[r_chk_idx] && !r_done[r_chk_idx] &&
                        efg_pkg::cond_holds(r_flags, rd_cfg.mask, rd_cfg.need_all)) begin
                        n_done[r_chk_idx] = 1'b1;
                        snap_we           = 1'b1;
                        res.valid         = 1'b1;
                        res.kind          = efg_pkg::K_WAKE;
                        res.value         = r_flags;
                        res.slot          = 3'(r_chk_idx);
                    end
                end else if (r_rd_idx == CW'(W)) begin
                    res.valid = 1'b1;
                    res.kind  = efg_pkg::K_FLAGS;
                    res.value = r_flags;
                    res.last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_FIN: begin
                // slot condition is on the read port now
                rd_addr = r_fin_slot;
                if (r_fin_woken && r_done[r_fin_slot]) begin
                    fin_ret = rd_snap;
                    fin_ok  = 1'b1;
                end else if (efg_pkg::cond_holds(r_flags, rd_cfg.mask, rd_cfg.need_all)) begin
                    fin_ret = r_flags;
                    fin_ok  = 1'b1;
                end
                if (fin_ok && rd_cfg.clear_after) begin
                    n_flags = r_flags & ~rd_cfg.mask;
                end
                n_busy[r_fin_slot] = 1'b0;
                n_done[r_fin_slot] = 1'b0;
                res.valid = 1'b1;
                res.kind  = efg_pkg::K_FINISH;
                res.value = fin_ret;
                res.slot  = 3'(r_fin_slot);
                res.last  = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_flags   <= '0;
            r_busy    <= '0;
            r_done    <= '0;
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flags   <= n_flags;
            r_busy    <= n_busy;
            r_done    <= n_done;
            r_rd_idx  <= n_rd_idx;
            r_chk_vld <= n_chk_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk_idx   <= n_chk_idx;
        r_fin_slot  <= n_fin_slot;
        r_fin_woken <= n_fin_woken;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = res;

    // a slot can only be done while it is held
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done & ~r_busy) == '0)
        else $error("done bit set on a free slot");

    // the check stage only runs during a set walk
    a_chk_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_state == S_SET))
        else $error("slot check outside a set walk");

    // wake results come only from the set walk
    a_wake_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.kind == efg_pkg::K_WAKE) |-> (r_state == S_SET && !res.last))
        else $error("wake result outside a set walk");

    // the final result of a transaction returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.last) |=> (r_state == S_IDLE))
        else $error("not idle after final result");

endmodule

// ===== hw/rtl/event_flag_group.sv =====
// event flag group top level: sequencer and registered result port
//
//  channel   direction  handshake                        payload
//  command   in         start high while busy low        i_op i_mask i_need_all
//                                                         i_clear_after i_poll_only
//                                                         i_slot_id i_was_woken
//  result    out        o_strobe for one cycle           o_kind o_value o_slot o_last
//
// clear and wait: result in the cycle after the accept, busy stays low, so one per cycle.
// finish: the sequencer waits in S_FIN for the single slot table read.
// set: S_SET walks the slot table, one slot table read per cycle, then gives the flags.
// reset is synchronous active low; all slots free and flags zero after it.
// results cannot be held off: each stays on the ports for exactly one cycle.
`timescale 1ns / 1ps

module event_flag_group (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_mask,
    input  logic        i_need_all,
    input  logic        i_clear_after,
    input  logic        i_poll_only,
    input  logic [2:0]  i_slot_id,
    input  logic        i_was_woken,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [31:0] o_value,
    output logic [2:0]  o_slot,
    output logic        o_last
);

    efg_pkg::t_res res;
    logic          seq_busy;
    logic          r_strobe;
    logic [2:0]    r_kind;
    logic [31:0]   r_value;
    logic [2:0]    r_slot;
    logic          r_last;

    efg_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_op          (i_op),
        .i_mask        (i_mask),
        .i_need_all    (i_need_all),
        .i_clear_after (i_clear_after),
        .i_poll_only   (i_poll_only),
        .i_slot_id     (i_slot_id),
        .i_was_woken   (i_was_woken),
        .o_busy        (seq_busy),
        .o_res         (res)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res.valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_kind  <= res.kind;
        r_value <= res.value;
        r_slot  <= res.slot;
        r_last  <= res.last;
    end

    assign busy     = seq_busy;
    assign o_strobe = r_strobe;
    assign o_kind   = r_kind;
    assign o_value  = r_value;
    assign o_slot   = r_slot;
    assign o_last   = r_last;

endmodule

// ===== dv/tb_event_flag_group.sv =====
// self-checking testbench for the event flag group: directed table, then random commands
`timescale 1ns / 1ps

module tb_event_flag_group;
    import efg_pkg::*;

    localparam int RES_MAX  = WAITERS + 1;
    localparam int N_RANDOM = 345;
    localparam int N_CALM   = 60;

    // one command plus an optional typed-in expectation
    typedef struct packed {
        t_op         op;
        logic [31:0] mask;
        logic        need_all;
        logic        clear_after;
        logic        poll_only;
        logic [2:0]  slot_id;
        logic        was_woken;
        logic        typed;
        t_kind       exp_kind;
        logic [31:0] exp_value;
        logic [2:0]  exp_slot;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [2:0]  slot;
        logic        last;
    } t_flag_result;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    logic  o_strobe;
    logic  [2:0] o_kind;
    logic  [31:0] o_value;
    logic  [2:0] o_slot;
    logic  o_last;
    t_cmd  cur_cmd;

    // flag group state as the testbench sees it
    logic [31:0] flags_m;
    logic [31:0] slot_mask_m [WAITERS];
    logic        slot_all_m [WAITERS];
    logic        slot_clr_m [WAITERS];
    logic        slot_busy_m [WAITERS];
    logic        slot_done_m [WAITERS];
    logic [31:0] slot_snap_m [WAITERS];

    t_flag_result pending_results [$];
    t_cmd         directed [$];
    int           n_accepted;
    int           n_results;
    int           n_errors;
    int           kind_seen [8];

    event_flag_group dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (cur_cmd.op),
        .i_mask        (cur_cmd.mask),
        .i_need_all    (cur_cmd.need_all),
        .i_clear_after (cur_cmd.clear_after),
        .i_poll_only   (cur_cmd.poll_only),
        .i_slot_id     (cur_cmd.slot_id),
        .i_was_woken   (cur_cmd.was_woken),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_slot        (o_slot),
        .o_last        (o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // any / all condition on the flag word
    function automatic logic wait_satisfied(input logic [31:0] cur, input logic [31:0] want,
                                            input logic all);
        if (all) return (cur & want) == want;
        return (cur & want) != 32'h0;
    endfunction

    function automatic t_flag_result mk_result(input t_kind k, input logic [31:0] v,
                                               input logic [2:0] s, input logic l);
        t_flag_result r;
        r.kind  = k;
        r.value = v;
        r.slot  = s;
        r.last  = l;
        return r;
    endfunction

    // advance the flag group state by one command and list the results it causes
    function automatic void flag_group_step(input t_cmd c, output t_flag_result res [RES_MAX],
                                            output int n);
        logic [31:0] ret;
        int          sid;
        bit          queued;
        n = 0;
        case (c.op)
            OP_SET: begin
                flags_m = flags_m | c.mask;
                for (int s = 0; s < WAITERS; s++) begin
                    if (slot_busy_m[s] && !slot_done_m[s] &&
                        wait_satisfied(flags_m, slot_mask_m[s], slot_all_m[s])) begin
                        slot_done_m[s] = 1'b1;
                        slot_snap_m[s] = flags_m;
                        res[n] = mk_result(K_WAKE, flags_m, 3'(s), 1'b0);
                        n++;
                    end
                end
                res[n] = mk_result(K_FLAGS, flags_m, 3'd0, 1'b1);
                n++;
            end
            OP_CLEAR: begin
                flags_m = flags_m & ~c.mask;
                res[0] = mk_result(K_FLAGS, flags_m, 3'd0, 1'b1);
                n = 1;
            end
            OP_WAIT: begin
                n = 1;
                if (c.mask == 32'h0) begin
                    res[0] = mk_result(K_EMPTY, 32'h0, 3'd0, 1'b1);
                end else if (wait_satisfied(flags_m, c.mask, c.need_all)) begin
                    res[0] = mk_result(K_MET, flags_m, 3'd0, 1'b1);
                    if (c.clear_after) flags_m = flags_m & ~c.mask;
                end else if (c.poll_only) begin
                    res[0] = mk_result(K_POLL, 32'h0, 3'd0, 1'b1);
                end else begin
                    queued = 1'b0;
                    for (int s = 0; s < WAITERS; s++) begin
                        if (!queued && !slot_busy_m[s]) begin
                            slot_mask_m[s] = c.mask;
                            slot_all_m[s]  = c.need_all;
                            slot_clr_m[s]  = c.clear_after;
                            slot_done_m[s] = 1'b0;
                            slot_snap_m[s] = 32'h0;
                            slot_busy_m[s] = 1'b1;
                            res[0] = mk_result(K_QUEUED, 32'h0, 3'(s), 1'b1);
                            queued = 1'b1;
                        end
                    end
                    if (!queued) res[0] = mk_result(K_NOSLOT, 32'h0, 3'd0, 1'b1);
                end
            end
            default: begin
                n   = 1;
                sid = int'(c.slot_id);
                if (sid >= WAITERS || !slot_busy_m[sid]) begin
                    res[0] = mk_result(K_FINISH, 32'h0, c.slot_id, 1'b1);
                end else begin
                    ret = 32'h0;
                    // a signalled waiter returns its snapshot, otherwise re-check the flags
                    if (c.was_woken && slot_done_m[sid]) begin
                        ret = slot_snap_m[sid];
                        if (slot_clr_m[sid]) flags_m = flags_m & ~slot_mask_m[sid];
                    end else if (wait_satisfied(flags_m, slot_mask_m[sid], slot_all_m[sid])) begin
                        ret = flags_m;
                        if (slot_clr_m[sid]) flags_m = flags_m & ~slot_mask_m[sid];
                    end
                    slot_busy_m[sid] = 1'b0;
                    slot_done_m[sid] = 1'b0;
                    res[0] = mk_result(K_FINISH, ret, c.slot_id, 1'b1);
                end
            end
        endcase
    endfunction

    // compare one result field
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // result checking first, then prediction of the transaction accepted at this edge
    always @(posedge i_clk) begin
        t_flag_result want;
        t_flag_result res [RES_MAX];
        int           n;
        if (i_rst_n) begin
            if (o_strobe) begin
                n_results++;
                kind_seen[o_kind]++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%08h slot %0d last %0d",
                           o_kind, o_value, o_slot, o_last);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(o_kind));
                    check_field("value", want.value, o_value);
                    check_field("slot", 32'(want.slot), 32'(o_slot));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
            if (start && !busy) begin
                flag_group_step(cur_cmd, res, n);
                if (cur_cmd.typed) begin
                    pending_results.push_back(mk_result(cur_cmd.exp_kind, cur_cmd.exp_value,
                                                        cur_cmd.exp_slot, 1'b1));
                end else begin
                    for (int k = 0; k < n; k++) pending_results.push_back(res[k]);
                end
                n_accepted++;
            end
        end
    end

    function automatic t_cmd row(input t_op op, input logic [31:0] mask, input logic all,
                                 input logic clr, input logic poll, input logic [2:0] sid,
                                 input logic woken, input logic typed, input t_kind k,
                                 input logic [31:0] v, input logic [2:0] s);
        t_cmd c;
        c.op          = op;
        c.mask        = mask;
        c.need_all    = all;
        c.clear_after = clr;
        c.poll_only   = poll;
        c.slot_id     = sid;
        c.was_woken   = woken;
        c.typed       = typed;
        c.exp_kind    = k;
        c.exp_value   = v;
        c.exp_slot    = s;
        return c;
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 11))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return 32'h1 << $urandom_range(0, 31);
            5, 6, 7: return ($urandom & $urandom & 32'h0000_00FF) << (8 * $urandom_range(0, 3));
            8:       return 32'h0000_000F << (4 * $urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // random command, biased toward live waiters so wake and finish paths get exercised
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   live [$];
        int   r;
        for (int s = 0; s < WAITERS; s++) if (slot_busy_m[s]) live.push_back(s);
        c = t_cmd'({$urandom, $urandom, $urandom});
        c.typed       = 1'b0;
        c.mask        = pick_mask();
        c.need_all    = 1'($urandom);
        c.clear_after = 1'($urandom);
        c.poll_only   = ($urandom_range(0, 3) == 0);
        c.slot_id     = 3'($urandom);
        c.was_woken   = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 22)      c.op = OP_SET;
        else if (r < 34) c.op = OP_CLEAR;
        else if (r < 68) c.op = OP_WAIT;
        else             c.op = OP_FINISH;
        if (c.op == OP_FINISH && live.size() != 0 && $urandom_range(0, 4) != 0) begin
            c.slot_id = 3'(live[$urandom_range(0, live.size() - 1)]);
            if (slot_done_m[c.slot_id]) c.was_woken = ($urandom_range(0, 4) != 0);
        end
        return c;
    endfunction

    // drive one command at the falling edge, after an optional idle burst
    task automatic issue(input t_cmd c, input int gap);
        int seen;
        if (gap > 0) begin
            start   <= 1'b0;
            cur_cmd <= rand_cmd();
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        cur_cmd <= c;
        seen = n_accepted;
        do @(negedge i_clk); while (n_accepted == seen);
    endtask

    // directed table: error codes, extremes, full table, wake walk, fallback finish
    initial begin
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd0, 1, 1, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd7, 0, 1, K_FINISH, 0, 3'd7));
        directed.push_back(row(OP_WAIT,   32'h0,         1, 1, 0, 3'd0, 0, 1, K_EMPTY,  0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'hFFFF_FFFF, 0, 0, 1, 3'd0, 0, 1, K_POLL,   0, 3'd0));
        directed.push_back(row(OP_SET,    32'h0,         0, 0, 0, 3'd0, 0, 1, K_FLAGS,  0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'h0000_0001, 0, 0, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'h8000_0000, 1, 1, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd1));
        directed.push_back(row(OP_WAIT,   32'h0000_0003, 1, 0, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd2));
        directed.push_back(row(OP_WAIT,   32'h0000_00F0, 0, 0, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd3));
        directed.push_back(row(OP_WAIT,   32'hFFFF_FFFF, 1, 1, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd4));
        directed.push_back(row(OP_WAIT,   32'h0000_0100, 0, 0, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd5));
        directed.push_back(row(OP_WAIT,   32'h0000_FFFF, 1, 0, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd6));
        directed.push_back(row(OP_WAIT,   32'h0001_0000, 0, 1, 0, 3'd0, 0, 1, K_QUEUED, 0, 3'd7));
        directed.push_back(row(OP_WAIT,   32'h0000_0002, 0, 0, 0, 3'd0, 0, 1, K_NOSLOT, 0, 3'd0));
        // every waiter wakes at once: eight wakes then the flags
        directed.push_back(row(OP_SET,    32'hFFFF_FFFF, 0, 0, 0, 3'd0, 0, 0, K_FLAGS,  0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'h8000_0000, 1, 1, 0, 3'd0, 0, 1, K_MET,
                               32'hFFFF_FFFF, 3'd0));
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd1, 1, 0, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd0, 0, 0, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_CLEAR,  32'hFFFF_FFFF, 0, 0, 0, 3'd0, 0, 1, K_FLAGS,  0, 3'd0));
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd4, 1, 0, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd2, 0, 0, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'hAAAA_AAAA, 1, 0, 1, 3'd0, 0, 1, K_POLL,   0, 3'd0));
        directed.push_back(row(OP_WAIT,   32'h0000_0005, 0, 0, 0, 3'd0, 0, 0, K_QUEUED, 0, 3'd0));
        // signalled but never woken: falls back to the current flags
        directed.push_back(row(OP_FINISH, 32'h0,         0, 0, 0, 3'd0, 1, 0, K_FINISH, 0, 3'd0));
        directed.push_back(row(OP_SET,    32'h0000_0005, 0, 0, 0, 3'd0, 0, 0, K_FLAGS,  0, 3'd0));
    end

    // stimulus and end of run
    initial begin
        int gap;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        cur_cmd    = '0;
        n_accepted = 0;
        n_results  = 0;
        n_errors   = 0;
        flags_m    = 32'h0;
        for (int s = 0; s < WAITERS; s++) begin
            slot_mask_m[s] = 32'h0;
            slot_all_m[s]  = 1'b0;
            slot_clr_m[s]  = 1'b0;
            slot_busy_m[s] = 1'b0;
            slot_done_m[s] = 1'b0;
            slot_snap_m[s] = 32'h0;
        end
        for (int k = 0; k < 8; k++) kind_seen[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            issue(directed[k], gap);
        end

        // random part, with quiet stretches and no idling at the tail
        for (int i = 0; i < N_RANDOM; i++) begin
            gap = 0;
            if (i < N_RANDOM - N_CALM && (i % 50) >= 15 && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 12);
            issue(rand_cmd(), gap);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (WAITERS + 12) @(negedge i_clk);

        $display("%0d transactions sent, %0d results checked", n_accepted, n_results);
        $display("by kind: flags %0d wake %0d met %0d queued %0d poll %0d noslot %0d fin %0d empty %0d",
                 kind_seen[K_FLAGS], kind_seen[K_WAKE], kind_seen[K_MET], kind_seen[K_QUEUED],
                 kind_seen[K_POLL], kind_seen[K_NOSLOT], kind_seen[K_FINISH], kind_seen[K_EMPTY]);
        if (n_errors == 0) begin
            $display("tb_event_flag_group passed");
        end else begin
            $display("tb_event_flag_group failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("tb_event_flag_group failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/efg_pkg.sv
hw/rtl/efg_slot_ram.sv
hw/rtl/efg_seq.sv
hw/rtl/event_flag_group.sv
dv/tb_event_flag_group.sv
